[design/lpb_pkg.sv]
package lpb_pkg;

    // Width of each step count on the input side.
    localparam int STEP_W = 5;

    // Width of the result field.
    localparam int COUNT_W = 59;

    // Width of the running product and quotient. Every intermediate value fits here.
    localparam int ACC_W = 64;

    // Default for the largest step count that is accepted on either input.
    localparam int MAX_STEPS_DEF = 31;

endpackage

[design/lattice_path_binomial_core.sv]
// This core counts the monotone lattice paths through a grid of steps_right by steps_down
// steps, which is the binomial coefficient C(right+down, right). It runs one request at a
// time. It starts from one, and for i = 1..right it multiplies the running value by
// (n+1-i), where n = right+down, and then divides it exactly by i. A six-bit multiplier
// does each multiply. The divide runs on a restoring divider that makes one quotient bit
// per cycle. A request with zero right steps goes straight to the done state with a
// result of one. Each step count is clamped to MAX_STEPS. The input is not ready while a
// request is in work. A finished result waits in the output register until its beat is
// taken. The core takes the next request during that wait. No state is kept from one
// request to the next.
module lattice_path_binomial_core #(
    parameter int MAX_STEPS = lpb_pkg::MAX_STEPS_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_in_valid,
    output logic                         o_in_ready,
    input  logic [lpb_pkg::STEP_W-1:0]   i_steps_right,
    input  logic [lpb_pkg::STEP_W-1:0]   i_steps_down,
    output logic                         o_out_valid,
    input  logic                         i_out_ready,
    output logic [lpb_pkg::COUNT_W-1:0]  o_path_count
);
    import lpb_pkg::*;

    localparam int N_W   = STEP_W + 1;
    localparam int CNT_W = $clog2(ACC_W);

    // Sequencer states.
    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_MUL  = 2'd1;
    localparam logic [1:0] ST_DIV  = 2'd2;
    localparam logic [1:0] ST_DONE = 2'd3;

    logic [1:0]         r_state, n_state;
    logic [STEP_W-1:0]  r_k, n_k;          // right steps, the number of passes
    logic [N_W-1:0]     r_n, n_n;          // total steps
    logic [STEP_W-1:0]  r_i, n_i;          // current pass index, also the divisor
    logic [ACC_W-1:0]   r_acc, n_acc;      // running value; the quotient shifts in here
    logic [STEP_W-1:0]  r_rem, n_rem;      // partial remainder, always below the divisor
    logic [CNT_W-1:0]   r_cnt, n_cnt;      // quotient bits still to produce, less one
    logic               r_out_valid, n_out_valid;
    logic [COUNT_W-1:0] r_path_count, n_path_count;

    logic [STEP_W-1:0]  w_right;
    logic [STEP_W-1:0]  w_down;
    logic [N_W-1:0]     w_factor;
    logic [ACC_W-1:0]   w_prod;
    logic [N_W-1:0]     w_trial;
    logic [N_W-1:0]     w_diff;
    logic               w_qbit;
    logic               w_take;

    function automatic logic [STEP_W-1:0] clamp_steps(input logic [STEP_W-1:0] v);
        logic [STEP_W-1:0] r;
        r = v;
        if (int'(v) > MAX_STEPS) begin
            r = STEP_W'(MAX_STEPS);
        end
        return r;
    endfunction

    assign w_right = clamp_steps(i_steps_right);
    assign w_down  = clamp_steps(i_steps_down);

    // The multiplier factor is n+1-i. It is at least down+1 and at most 62.
    assign w_factor = N_W'(({1'b0, r_n} + (N_W + 1)'(1)) - (N_W + 1)'(r_i));
    assign w_prod   = r_acc * ACC_W'(w_factor);

    // One restoring divide step. It brings the next dividend bit into the remainder.
    assign w_trial = {r_rem, r_acc[ACC_W-1]};
    assign w_diff  = w_trial - {1'b0, r_i};
    assign w_qbit  = (w_trial >= {1'b0, r_i});

    assign w_take = (r_state == ST_IDLE) && i_in_valid;

    always_comb begin
        n_state      = r_state;
        n_k          = r_k;
        n_n          = r_n;
        n_i          = r_i;
        n_acc        = r_acc;
        n_rem        = r_rem;
        n_cnt        = r_cnt;
        n_out_valid  = r_out_valid && !i_out_ready;
        n_path_count = r_path_count;

        unique case (r_state)
            ST_IDLE: begin
                if (w_take) begin
                    n_k   = w_right;
                    n_n   = {1'b0, w_right} + {1'b0, w_down};
                    n_i   = STEP_W'(1);
                    n_acc = ACC_W'(1);
                    if (w_right == '0) begin
                        n_state = ST_DONE;
                    end else begin
                        n_state = ST_MUL;
                    end
                end
            end
            ST_MUL: begin
                n_acc   = w_prod;
                n_rem   = '0;
                n_cnt   = CNT_W'(ACC_W - 1);
                n_state = ST_DIV;
            end
            ST_DIV: begin
                n_acc = {r_acc[ACC_W-2:0], w_qbit};
                n_rem = w_qbit ? w_diff[STEP_W-1:0] : w_trial[STEP_W-1:0];
                n_cnt = r_cnt - CNT_W'(1);
                if (r_cnt == '0) begin
                    if (r_i == r_k) begin
                        n_state = ST_DONE;
                    end else begin
                        n_i     = r_i + STEP_W'(1);
                        n_state = ST_MUL;
                    end
                end
            end
            ST_DONE: begin
                // Load the result once the output register is free or is being emptied.
                if (!r_out_valid || i_out_ready) begin
                    n_out_valid  = 1'b1;
                    n_path_count = r_acc[COUNT_W-1:0];
                    n_state      = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_k          <= n_k;
        r_n          <= n_n;
        r_i          <= n_i;
        r_acc        <= n_acc;
        r_rem        <= n_rem;
        r_cnt        <= n_cnt;
        r_path_count <= n_path_count;
    end

    assign o_in_ready   = (r_state == ST_IDLE);
    assign o_out_valid  = r_out_valid;
    assign o_path_count = r_path_count;

endmodule

[design/lpb_checker.sv]
module lpb_checker (
    input logic                         i_clk,
    input logic                         i_rst_n,
    input logic                         i_in_valid,
    input logic                         o_in_ready,
    input logic [lpb_pkg::STEP_W-1:0]   i_steps_right,
    input logic [lpb_pkg::STEP_W-1:0]   i_steps_down,
    input logic                         o_out_valid,
    input logic                         i_out_ready,
    input logic [lpb_pkg::COUNT_W-1:0]  o_path_count
);
    import lpb_pkg::*;

    // A result beat that waits holds its value.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !i_out_ready) |=> (o_out_valid && $stable(o_path_count)))
        else $error("stalled result beat changed or dropped");

    // An accepted request occupies the core for at least the next cycle.
    a_busy_after_take: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> !o_in_ready)
        else $error("core ready right after taking a request");

    // A path count is never zero.
    a_count_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_path_count != '0))
        else $error("zero path count delivered");

    // A new result appears only at the end of work, while the input is held off.
    a_result_from_work: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> !$past(o_in_ready))
        else $error("result appeared without a request in work");

endmodule

bind lattice_path_binomial_core lpb_checker u_lpb_checker (.*);
